FILE: rtl/laplacian_stencil_apply_top_assert.svh
// Assertion macros used by the stencil top level.
`ifndef LAPLACIAN_STENCIL_APPLY_TOP_ASSERT_SVH
`define LAPLACIAN_STENCIL_APPLY_TOP_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define LSA_ASSERT_ALWAYS(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Check a consequence in the same cycle as its trigger.
`define LSA_ASSERT_IMPLIES(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequence in the cycle after its trigger.
`define LSA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/lsa_pkg.sv
// Shared constants for the five-point Laplacian stencil.
`timescale 1ns / 1ps
package lsa_pkg;
   localparam int DEF_MAX_SIDE = 64;
   localparam int SAMPLE_W     = 32;
   localparam int RESULT_W     = 35;
   localparam int INDEX_W      = 12;
   localparam int SIDE_W       = 7;
   localparam int SIDE_RESET   = 64;
   localparam int SIDE_MIN     = 2;
   localparam int RSP_DATA_W   = 48;
endpackage

FILE: rtl/laplacian_stencil_apply_top.sv
// Top level of the five-point Laplacian stencil over a raster-order square grid.
`timescale 1ns / 1ps
//
// Usage:
//  - req channel carries one grid sample per request (tdata, signed Q16.16) in raster
//    order; tuser high marks a pad request whose sample counts as zero.
//  - rsp channel returns the stencil value of one grid point per response:
//    tdata = {zero, point_index[11:0], result[34:0]} (Q19.16), tlast on the final point.
//  - csr_wr_en/csr_wr_data set the grid side (clamped to 2..MAX_SIDE) and restart
//    the grid; write it only while the block is idle.
//  - Point p is emitted when request p + side is accepted, so the first side
//    requests of a grid return nothing; send side pad requests after the grid
//    to flush the last row. After the tlast response the next request is point 0.
//  - Throughput: one request per cycle while responses are taken. The response
//    is registered and appears in the cycle after the request that completes it.
//    The rate is set by the line buffer, which takes one write and two reads per cycle.
//  - Reset (synchronous) sets the side to 64 and empties the output register;
//    the line buffer needs no clearing, since no slot's value is used before it is written.
//  - A stalled receiver holds the response register; req_tready then drops until
//    the response is taken, and a request is taken in the same cycle as it leaves.
module laplacian_stencil_apply_top import lsa_pkg::*; #(
   parameter int MAX_SIDE = DEF_MAX_SIDE
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [SAMPLE_W-1:0]   req_tdata,   // [31:0] sample
   input  logic                  req_tuser,   // [0] pad
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [34:0] result, [46:35] point_index, [47] zero
   output logic                  rsp_tlast,
   input  logic                  csr_wr_en,
   input  logic [SIDE_W-1:0]     csr_wr_data
);
   localparam int NW    = $clog2(MAX_SIDE + 1);
   localparam int KW    = $clog2(MAX_SIDE * MAX_SIDE + MAX_SIDE + 1);
   localparam int DEPTH = 2 * MAX_SIDE + 1;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = (NW > SIDE_W) ? NW : SIDE_W;
   localparam int RST_N = (SIDE_RESET < SIDE_MIN) ? SIDE_MIN :
                          ((SIDE_RESET > MAX_SIDE) ? MAX_SIDE : SIDE_RESET);
   localparam int RST_TOTAL = RST_N * RST_N;
   localparam int RST_LAST  = RST_TOTAL + RST_N - 1;

   function automatic logic [NW-1:0] clamp_side(input logic [SIDE_W-1:0] s);
      logic [CW-1:0] e;
      e = CW'(s);
      if (e < CW'(SIDE_MIN)) return NW'(SIDE_MIN);
      if (e > CW'(MAX_SIDE)) return NW'(MAX_SIDE);
      return NW'(e);
   endfunction

   // grid geometry
   logic [NW-1:0] n_ff, n_in;
   logic [KW-1:0] total_ff, total_in;
   logic [KW-1:0] last_k_ff, last_k_in;
   // stream position
   logic [KW-1:0] k_ff, k_in;
   logic [NW-1:0] col_ff, col_in;
   logic [AW-1:0] wp_ff, wp_in;
   // stencil window: center and left neighbor of the next point
   logic signed [SAMPLE_W-1:0] center_ff, center_in;
   logic signed [SAMPLE_W-1:0] left_ff, left_in;
   // response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RESULT_W-1:0] result_ff, result_in;
   logic [INDEX_W-1:0]  index_ff, index_in;
   logic                last_ff, last_in;

   logic accept;
   logic in_grid, has_out, has_up, at_end, col_final;
   logic signed [SAMPLE_W-1:0] x;
   logic signed [SAMPLE_W-1:0] right_rd, up_rd;
   logic signed [RESULT_W-1:0] t_center, t_up, t_left, t_right, t_down, acc;
   logic [NW-1:0] csr_n;
   logic [KW-1:0] csr_total;
   logic [AW:0]   ra_right_sum, ra_up_sum;
   logic [AW-1:0] ra_right, ra_up;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign in_grid   = k_ff < total_ff;
   assign has_out   = k_ff >= KW'(n_ff);
   assign has_up    = k_ff >= (KW'(n_ff) << 1);
   assign at_end    = k_ff == last_k_ff;
   assign col_final = col_ff == (n_ff - 1'b1);

   // a pad request, or any request past the grid, feeds a zero sample
   assign x = (req_tuser || !in_grid) ? '0 : $signed(req_tdata);

   // 4*center minus whichever neighbors lie inside the grid
   assign t_center = RESULT_W'(center_ff) <<< 2;
   assign t_up     = has_up ? RESULT_W'(up_rd) : '0;
   assign t_left   = (col_ff != '0) ? RESULT_W'(left_ff) : '0;
   assign t_right  = col_final ? '0 : RESULT_W'(right_rd);
   assign t_down   = RESULT_W'(x);
   assign acc      = t_center - t_up - t_left - t_right - t_down;

   assign csr_n     = clamp_side(csr_wr_data);
   assign csr_total = KW'(csr_n) * KW'(csr_n);

   always_comb begin
      n_in         = n_ff;
      total_in     = total_ff;
      last_k_in    = last_k_ff;
      k_in         = k_ff;
      col_in       = col_ff;
      wp_in        = wp_ff;
      center_in    = center_ff;
      left_in      = left_ff;
      rsp_valid_in = rsp_valid_ff;
      result_in    = result_ff;
      index_in     = index_ff;
      last_in      = last_ff;
      if (reset) begin
         n_in         = NW'(RST_N);
         total_in     = KW'(RST_TOTAL);
         last_k_in    = KW'(RST_LAST);
         k_in         = '0;
         col_in       = '0;
         wp_in        = '0;
         rsp_valid_in = 1'b0;
      end else begin
         if (accept) begin
            k_in      = at_end ? '0 : k_ff + 1'b1;
            wp_in     = (wp_ff == AW'(DEPTH - 1)) ? '0 : wp_ff + 1'b1;
            // advance the window by one sample
            center_in = right_rd;
            left_in   = center_ff;
            rsp_valid_in = has_out;
            if (has_out) begin
               col_in    = col_final ? '0 : col_ff + 1'b1;
               result_in = acc;
               index_in  = INDEX_W'(k_ff - KW'(n_ff));
               last_in   = at_end;
            end
         end else if (rsp_tready) begin
            rsp_valid_in = 1'b0;
         end
         // a side write restarts the grid
         if (csr_wr_en) begin
            n_in      = csr_n;
            total_in  = csr_total;
            last_k_in = csr_total + KW'(csr_n) - 1'b1;
            k_in      = '0;
            col_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      total_ff     <= total_in;
      last_k_ff    <= last_k_in;
      k_ff         <= k_in;
      col_ff       <= col_in;
      wp_ff        <= wp_in;
      center_ff    <= center_in;
      left_ff      <= left_in;
      rsp_valid_ff <= rsp_valid_in;
      result_ff    <= result_in;
      index_ff     <= index_in;
      last_ff      <= last_in;
   end

   // fetch for the next request: right neighbor (k-n+1) and up neighbor (k-2n)
   assign ra_right_sum = (AW + 1)'(wp_in) + (AW + 1)'(DEPTH) - (AW + 1)'(n_in) + 1'b1;
   assign ra_up_sum    = (AW + 1)'(wp_in) + (AW + 1)'(DEPTH) - ((AW + 1)'(n_in) << 1);
   assign ra_right = (ra_right_sum >= (AW + 1)'(DEPTH)) ?
                     AW'(ra_right_sum - (AW + 1)'(DEPTH)) : AW'(ra_right_sum);
   assign ra_up    = (ra_up_sum >= (AW + 1)'(DEPTH)) ?
                     AW'(ra_up_sum - (AW + 1)'(DEPTH)) : AW'(ra_up_sum);

   lsa_line_buf #(
      .MAX_SIDE (MAX_SIDE)
   ) u_line_buf (
      .clock     (clock),
      .wr_en     (accept),
      .wr_addr   (wp_ff),
      .wr_data   (x),
      .rd_addr_a (ra_right),
      .rd_addr_b (ra_up),
      .rd_data_a (right_rd),
      .rd_data_b (up_rd)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, index_ff, result_ff};
   assign rsp_tlast  = last_ff;

`include "laplacian_stencil_apply_top_assert.svh"

   `LSA_ASSERT_ALWAYS(a_pos_in_range, k_ff <= last_k_ff, "stream position past grid end")
   `LSA_ASSERT_ALWAYS(a_col_in_range, col_ff < n_ff, "column position past row end")
   `LSA_ASSERT_NEXT(a_out_follows, accept && has_out, rsp_valid_ff, "response not registered")
   `LSA_ASSERT_IMPLIES(a_last_index, rsp_valid_ff && last_ff, index_ff == INDEX_W'(total_ff - 1'b1), "tlast on wrong point")
endmodule

FILE: rtl/lsa_line_buf.sv
// Line buffer: circular sample store with one write and two registered reads.
`timescale 1ns / 1ps
module lsa_line_buf import lsa_pkg::*; #(
   parameter int MAX_SIDE = DEF_MAX_SIDE,
   localparam int DEPTH = 2 * MAX_SIDE + 1,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [AW-1:0]              wr_addr,
   input  logic signed [SAMPLE_W-1:0] wr_data,
   input  logic [AW-1:0]              rd_addr_a,
   input  logic [AW-1:0]              rd_addr_b,
   output logic signed [SAMPLE_W-1:0] rd_data_a,
   output logic signed [SAMPLE_W-1:0] rd_data_b
);
   logic signed [SAMPLE_W-1:0] mem [DEPTH];
   logic signed [SAMPLE_W-1:0] rd_a_ff;
   logic signed [SAMPLE_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // forward a sample written in the same cycle as it is read
   always_ff @(posedge clock) begin
      rd_a_ff <= (wr_en && (wr_addr == rd_addr_a)) ? wr_data : mem[rd_addr_a];
      rd_b_ff <= (wr_en && (wr_addr == rd_addr_b)) ? wr_data : mem[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;
endmodule

FILE: sim/laplacian_stencil_apply_top_test.sv
// Self-checking testbench for the five-point Laplacian stencil block.
`timescale 1ns / 1ps
module laplacian_stencil_apply_top_test;
   import lsa_pkg::*;

   localparam int LINE_DEPTH    = 2 * DEF_MAX_SIDE + 1;
   localparam int DIRECTED_ROWS = 24;
   localparam int RANDOM_ITEMS  = 1350;
   localparam int PLAN_LEN      = 18;
   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 4;
   localparam int DRAIN_CYCLES  = 8;
   localparam int HOLD_CYCLES   = 150;
   localparam int FULL_RATE_SIDE = 16;

   localparam logic [SAMPLE_W-1:0] MAX_P = 32'h7FFF_FFFF;
   localparam logic [SAMPLE_W-1:0] MIN_N = 32'h8000_0000;
   // Uniform side-2 grids: every point is a corner and sees 4*v - 2*v.
   localparam logic [RESULT_W-1:0] TWICE_MAX = 35'h0_FFFF_FFFE;
   localparam logic [RESULT_W-1:0] TWICE_MIN = 35'h7_0000_0000;
   // Centre at the top, all four neighbours at the bottom.
   localparam logic [RESULT_W-1:0] PEAK      = 35'h3_FFFF_FFFC;

   typedef struct packed {
      logic signed [RESULT_W-1:0] value;
      logic [INDEX_W-1:0]         point;
      logic                       is_last;
   } point_result_type;

   typedef struct packed {
      logic                set_side;
      logic [SIDE_W-1:0]   side_val;
      logic [SAMPLE_W-1:0] sample;
      logic                pad;
      logic                typed;
      point_result_type    want;
   } stim_row_type;

   localparam point_result_type NO_WANT = '0;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [SAMPLE_W-1:0]   req_tdata;   // [31:0] sample
   logic                  req_tuser;   // [0] pad
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // [34:0] result, [46:35] point_index, [47] zero
   logic                  rsp_tlast;
   logic                  csr_wr_en;
   logic [SIDE_W-1:0]     csr_wr_data;

   // Predictor state
   logic [SIDE_W-1:0] side_setting;
   longint            line_store [0:LINE_DEPTH-1];
   int unsigned       grid_pos;
   int unsigned       point_col;
   point_result_type  expected_points [$];

   bit           full_rate;
   int           requests_sent;
   int           mismatch_count;
   stim_row_type dir_rows [0:DIRECTED_ROWS-1];
   logic [SIDE_W-1:0] side_plan [0:PLAN_LEN-1];

   laplacian_stencil_apply_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int unsigned active_side();
      if (side_setting < SIDE_MIN) return SIDE_MIN;
      if (side_setting > DEF_MAX_SIDE) return DEF_MAX_SIDE;
      return 32'(side_setting);
   endfunction

   // Advance the stencil state by one request; the point one row up is finished
   // once its lower neighbour arrives.
   function automatic void predict_point(input logic [SAMPLE_W-1:0] sample, input logic pad,
                                         output bit produced, output point_result_type want);
      int unsigned n, total, k, p;
      longint x, acc;
      n = active_side();
      total = n * n;
      k = grid_pos;
      x = (pad || k >= total) ? 0 : longint'(signed'(sample));
      produced = 1'b0;
      want = '0;
      if (k >= n) begin
         p = k - n;
         acc = 4 * line_store[p % LINE_DEPTH];
         if (p >= n) acc -= line_store[(p - n) % LINE_DEPTH];
         if (point_col > 0) acc -= line_store[(p - 1) % LINE_DEPTH];
         if (point_col + 1 < n) acc -= line_store[(p + 1) % LINE_DEPTH];
         if (k < total) acc -= x;
         want.value = acc[RESULT_W-1:0];
         want.point = INDEX_W'(p);
         want.is_last = (p == total - 1);
         produced = 1'b1;
         point_col = (point_col + 1 >= n) ? 0 : point_col + 1;
      end
      line_store[k % LINE_DEPTH] = x;
      if (k + 1 >= total + n) begin
         grid_pos = 0;
         point_col = 0;
      end else begin
         grid_pos = k + 1;
      end
   endfunction

   task automatic push_request(input logic [SAMPLE_W-1:0] sample, input logic pad,
                               input logic typed, input point_result_type typed_want);
      bit               produced;
      point_result_type want;
      while (!full_rate && $urandom_range(99) < 37) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= sample;
      req_tuser  <= pad;
      do @(posedge clock); while (!req_tready);
      predict_point(sample, pad, produced, want);
      if (produced) expected_points.push_back(typed ? typed_want : want);
      requests_sent++;
   endtask

   // Drain all pending points, then give rows that return nothing time to land.
   task automatic settle_block();
      req_tvalid <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_side(input logic [SIDE_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      side_setting = value;
      grid_pos = 0;
      point_col = 0;
   endtask

   initial begin : stimulus
      int unsigned       n, grid_len, phase_len, grids;
      int                plan_idx;
      logic [SIDE_W-1:0] side_code;
      logic [SAMPLE_W-1:0] smp;
      logic              pd;
      bit                in_grid;

      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= 1'b0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      side_setting = SIDE_W'(SIDE_RESET);
      grid_pos = 0;
      point_col = 0;
      foreach (line_store[j]) line_store[j] = 0;
      full_rate = 1'b0;
      requests_sent = 0;
      mismatch_count = 0;

      dir_rows = '{
         // side 2, all top values, flushed with pad requests
         '{1'b1, 7'd2, MAX_P, 1'b0, 1'b0, NO_WANT},
         '{1'b0, 7'd0, MAX_P, 1'b0, 1'b0, NO_WANT},
         '{1'b0, 7'd0, MAX_P, 1'b0, 1'b1, '{TWICE_MAX, 12'd0, 1'b0}},
         '{1'b0, 7'd0, MAX_P, 1'b0, 1'b1, '{TWICE_MAX, 12'd1, 1'b0}},
         '{1'b0, 7'd0, 32'h0, 1'b1, 1'b1, '{TWICE_MAX, 12'd2, 1'b0}},
         '{1'b0, 7'd0, 32'h0, 1'b1, 1'b1, '{TWICE_MAX, 12'd3, 1'b1}},
         // side 2, all bottom values, flushed with live samples that must be ignored
         '{1'b0, 7'd0, MIN_N, 1'b0, 1'b0, NO_WANT},
         '{1'b0, 7'd0, MIN_N, 1'b0, 1'b0, NO_WANT},
         '{1'b0, 7'd0, MIN_N, 1'b0, 1'b1, '{TWICE_MIN, 12'd0, 1'b0}},
         '{1'b0, 7'd0, MIN_N, 1'b0, 1'b1, '{TWICE_MIN, 12'd1, 1'b0}},
         '{1'b0, 7'd0, MAX_P, 1'b0, 1'b1, '{TWICE_MIN, 12'd2, 1'b0}},
         '{1'b0, 7'd0, 32'hFFFF_FFFF, 1'b0, 1'b1, '{TWICE_MIN, 12'd3, 1'b1}},
         // side 3: peak at the centre, pad inside the grid, mixed flush
         '{1'b1, 7'd3, 32'h5555_5555, 1'b0, 1'b0, NO_WANT},
         '{1'b0, 7'd0, MIN_N, 1'b0, 1'b0, NO_WANT},
         '{1'b0, 7'd0, 32'hAAAA_AAAA, 1'b0, 1'b0, NO_WANT},
         '{1'b0, 7'd0, MIN_N, 1'b0, 1'b0, NO_WANT},
         '{1'b0, 7'd0, MAX_P, 1'b0, 1'b0, NO_WANT},
         '{1'b0, 7'd0, MIN_N, 1'b0, 1'b0, NO_WANT},
         '{1'b0, 7'd0, 32'h0000_0001, 1'b0, 1'b0, NO_WANT},
         '{1'b0, 7'd0, MIN_N, 1'b0, 1'b1, '{PEAK, 12'd4, 1'b0}},
         '{1'b0, 7'd0, 32'hFFFF_FFFF, 1'b1, 1'b0, NO_WANT},
         '{1'b0, 7'd0, 32'h0, 1'b1, 1'b0, NO_WANT},
         '{1'b0, 7'd0, 32'h1234_5678, 1'b0, 1'b0, NO_WANT},
         '{1'b0, 7'd0, 32'hFFFF_FFFF, 1'b1, 1'b0, NO_WANT}
      };
      // Register extremes and clamped values first, then a spread of small sides.
      side_plan = '{7'd0, 7'd127, 7'd1, 7'd64, 7'd2, 7'd65, 7'd3, 7'd16, 7'd5,
                    7'd4, 7'd7, 7'd2, 7'd9, 7'd12, 7'd6, 7'd8, 7'd3, 7'd11};

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         if (dir_rows[i].set_side) begin
            settle_block();
            write_side(dir_rows[i].side_val);
         end
         push_request(dir_rows[i].sample, dir_rows[i].pad, dir_rows[i].typed, dir_rows[i].want);
      end

      plan_idx = 0;
      while (requests_sent < DIRECTED_ROWS + RANDOM_ITEMS) begin
         side_code = (plan_idx < PLAN_LEN) ? side_plan[plan_idx] : SIDE_W'($urandom_range(2, 12));
         plan_idx++;
         settle_block();
         full_rate = (side_code == FULL_RATE_SIDE);
         write_side(side_code);
         n = active_side();
         grid_len = n * n + n;
         if (n > FULL_RATE_SIDE) begin
            // Large sides: only a few rows, cut off by the next write.
            phase_len = n + $urandom_range(n / 2, n + 30);
         end else begin
            grids = (n > 8) ? 1 : $urandom_range(1, 3);
            phase_len = grids * grid_len;
            if ($urandom_range(99) < 30) phase_len += $urandom_range(1, grid_len - 1);
         end
         for (int unsigned j = 0; j < phase_len; j++) begin
            in_grid = (grid_pos < n * n);
            case ($urandom_range(4))
               0, 1: smp = $urandom;
               2: smp = SAMPLE_W'($urandom_range(512)) - 32'd256;
               3: begin
                  case ($urandom_range(3))
                     0: smp = MAX_P;
                     1: smp = MIN_N;
                     2: smp = 32'h0;
                     default: smp = 32'hFFFF_FFFF;
                  endcase
               end
               default: smp = {{16{1'($urandom_range(1))}}, 16'($urandom)};
            endcase
            pd = in_grid ? ($urandom_range(99) < 8) : ($urandom_range(99) < 85);
            push_request(smp, pd, 1'b0, NO_WANT);
         end
         full_rate = 1'b0;
      end

      req_tvalid <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

   // Result side: compare each point with the oldest prediction and stall at random.
   initial begin : response_side
      point_result_type want;
      int               hold_left;
      bit               hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            if (expected_points.size() == 0) begin
               $display("%0t: point with nothing expected: result %h, index %0d, last %b",
                        $time, rsp_tdata[RESULT_W-1:0], rsp_tdata[RESULT_W +: INDEX_W], rsp_tlast);
               mismatch_count++;
            end else begin
               want = expected_points.pop_front();
               if (rsp_tdata[RESULT_W-1:0] !== want.value) begin
                  $display("%0t: result of point %0d: expected %h, got %h",
                           $time, want.point, want.value, rsp_tdata[RESULT_W-1:0]);
                  mismatch_count++;
               end
               if (rsp_tdata[RESULT_W +: INDEX_W] !== want.point) begin
                  $display("%0t: point index: expected %0d, got %0d",
                           $time, want.point, rsp_tdata[RESULT_W +: INDEX_W]);
                  mismatch_count++;
               end
               if (rsp_tlast !== want.is_last) begin
                  $display("%0t: last flag of point %0d: expected %b, got %b",
                           $time, want.point, want.is_last, rsp_tlast);
                  mismatch_count++;
               end
               if (rsp_tdata[RSP_DATA_W-1] !== 1'b0) begin
                  $display("%0t: spare bit of point %0d: expected 0, got %b",
                           $time, want.point, rsp_tdata[RSP_DATA_W-1]);
                  mismatch_count++;
               end
            end
         end
         // Hold off once in the full-rate phase so the output register fills
         // and the block has to stall its input.
         if (!hold_done && full_rate && expected_points.size() != 0) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= full_rate || ($urandom_range(99) >= 37);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("TEST FAILED");
      $finish;
   end

endmodule

FILE: laplacian_stencil_apply_top.f
+incdir+rtl
rtl/lsa_pkg.sv
rtl/lsa_line_buf.sv
rtl/laplacian_stencil_apply_top.sv
sim/laplacian_stencil_apply_top_test.sv
